FILE: rtl/piecewise_linear_table_interpolator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the piecewise linear table interpolator
// Concurrent checks in a fixed form, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_ASSERT_SVH

// cond at an edge implies prop at the same edge
`define PLTI_ASSERT_IMPL(name, clock, reset, cond, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("plti: check failed");

// cond at an edge implies prop a fixed number of edges later
`define PLTI_ASSERT_DELAY(name, clock, reset, cond, n, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> ##n (prop)) \
    else $error("plti: latency check failed");

`endif

FILE: rtl/plti_pkg.sv
// ---------------------------------------------------------------------------
// plti_pkg
// Types, codes and constants of the piecewise linear table interpolator.
// ---------------------------------------------------------------------------
package plti_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int DEFAULT_FRAC_BITS   = 16;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [DATA_W-1:0]  RESET_IN_MIN      = 32'd0;
  localparam logic [DATA_W-1:0]  RESET_IN_MAX      = 32'd4128768;
  localparam logic [DATA_W-1:0]  RESET_INDEX_SCALE = 32'd65536;
  localparam logic [COUNT_W-1:0] RESET_POINT_COUNT = 7'd64;

  typedef enum logic [1:0] {
    REG_IN_MIN      = 2'd0,
    REG_IN_MAX      = 2'd1,
    REG_INDEX_SCALE = 2'd2,
    REG_POINT_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RANGE_INSIDE = 2'd0,
    RANGE_BELOW  = 2'd1,
    RANGE_ABOVE  = 2'd2
  } range_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  in_value;
    logic        [INDEX_W-1:0] entry_index;
    logic signed [DATA_W-1:0]  entry_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  out_value;
    logic        [INDEX_W-1:0] segment;
    range_t                    range_flag;
  } result_t;

endpackage

FILE: rtl/piecewise_linear_table_interpolator.sv
// ---------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Evenly spaced sample table with linear interpolation between entries.
//
// Usage:
//   An item transfers at a rising edge with start high and busy low. A write
//   item (op write) stores entry_value at entry_index and echoes it back. A
//   map item clamps in_value to [in_min, in_max], scales the offset by
//   index_scale, reads the two neighboring entries and interpolates.
//   Every item gives one result, shown on result for one cycle with done
//   high. The receiver cannot stall; results are never held.
//   Throughput: one item per cycle, set by the six-stage pipeline (offset,
//   scale multiply, table read with two read ports, difference, fraction
//   multiply, sum); busy is high only during reset.
//   The user must write configuration through cfg_we/cfg_index/cfg_data only
//   while no item is in flight (not enforced). Reset clears the pipeline
//   and loads default registers; table contents are undefined until written.
// ---------------------------------------------------------------------------
`include "piecewise_linear_table_interpolator_assert.svh"

module piecewise_linear_table_interpolator #(
  parameter int TABLE_DEPTH = plti_pkg::DEFAULT_TABLE_DEPTH,
  parameter int FRAC_BITS   = plti_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  plti_pkg::item_t                item,
  output logic                           done,
  output plti_pkg::result_t              result,
  input  logic                           cfg_we,
  input  plti_pkg::cfg_reg_t             cfg_index,
  input  logic [plti_pkg::DATA_W-1:0]    cfg_data
);
  import plti_pkg::*;

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int PROD_W  = 2 * DATA_W;
  localparam int IPART_W = PROD_W - 2 * FRAC_BITS;
  localparam int FR_W    = FRAC_BITS + 1;
  localparam int DELTA_W = DATA_W + 1;
  localparam int MUL_W   = DELTA_W + FR_W + 1;
  localparam int LATENCY = 6;

  logic signed [DATA_W-1:0]  in_min;
  logic signed [DATA_W-1:0]  in_max;
  logic        [DATA_W-1:0]  index_scale;
  logic        [COUNT_W-1:0] point_count;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;

  logic accept;

  // stage 1
  logic               v1;
  op_t                op1;
  logic               below1;
  logic               above1;
  logic [DATA_W-1:0]  diff1;
  logic [INDEX_W-1:0] widx1;
  logic [DATA_W-1:0]  wval1;

  // stage 2
  logic               v2;
  op_t                op2;
  logic               below2;
  logic               above2;
  logic [PROD_W-1:0]  prod2;
  logic [INDEX_W-1:0] widx2;
  logic [DATA_W-1:0]  wval2;

  logic [IPART_W-1:0]   ipart;
  logic [FRAC_BITS-1:0] frac_raw;
  logic                 over;
  logic [ADDR_W-1:0]    seg_next;
  logic [FR_W-1:0]      frac_next;
  logic                 interp_next;
  logic [ADDR_W-1:0]    addr_a;
  logic [ADDR_W-1:0]    addr_b;
  logic [INDEX_W-1:0]   seg_out_next;
  range_t               flag_next;
  logic                 wr_en;

  logic [DATA_W-1:0] mem [TABLE_DEPTH];

  // stage 3
  logic               v3;
  op_t                op3;
  range_t             flag3;
  logic [INDEX_W-1:0] seg3;
  logic [FR_W-1:0]    frac3;
  logic               interp3;
  logic [DATA_W-1:0]  wval3;
  logic [DATA_W-1:0]  rd_a;
  logic [DATA_W-1:0]  rd_b;

  // stage 4
  logic                      v4;
  range_t                    flag4;
  logic [INDEX_W-1:0]        seg4;
  logic [FR_W-1:0]           frac4;
  logic [DATA_W-1:0]         before4;
  logic signed [DELTA_W-1:0] delta4;

  // stage 5
  logic                    v5;
  range_t                  flag5;
  logic [INDEX_W-1:0]      seg5;
  logic [DATA_W-1:0]       before5;
  logic signed [MUL_W-1:0] mult5;

  logic signed [FR_W:0]    frac_s;
  logic signed [MUL_W-1:0] mult_next;
  logic signed [MUL_W-1:0] shifted;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_min      <= RESET_IN_MIN;
      in_max      <= RESET_IN_MAX;
      index_scale <= RESET_INDEX_SCALE;
      point_count <= RESET_POINT_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_MIN:      in_min      <= cfg_data;
        REG_IN_MAX:      in_max      <= cfg_data;
        REG_INDEX_SCALE: index_scale <= cfg_data;
        REG_POINT_COUNT: point_count <= cfg_data[COUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    if (point_count < COUNT_W'(2)) begin
      cnt = CNT_W'(2);
    end else if (32'(point_count) > 32'(TABLE_DEPTH)) begin
      cnt = CNT_W'(TABLE_DEPTH);
    end else begin
      cnt = CNT_W'(point_count);
    end
  end

  assign cnt_m1 = cnt - CNT_W'(1);
  assign cnt_m2 = cnt - CNT_W'(2);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // stage 1: bounds and offset
  always_ff @(posedge clk) begin
    op1    <= item.op;
    below1 <= item.in_value <= in_min;
    above1 <= item.in_value >= in_max;
    diff1  <= item.in_value - in_min;
    widx1  <= item.entry_index;
    wval1  <= item.entry_value;
  end

  // stage 2: scale the offset
  always_ff @(posedge clk) begin
    op2    <= op1;
    below2 <= below1;
    above2 <= above1;
    prod2  <= PROD_W'(diff1) * PROD_W'(index_scale);
    widx2  <= widx1;
    wval2  <= wval1;
  end

  // segment select and clamp
  assign ipart    = prod2[PROD_W-1 -: IPART_W];
  assign frac_raw = prod2[2*FRAC_BITS-1 -: FRAC_BITS];
  assign over     = ipart > IPART_W'(cnt_m2);

  always_comb begin
    interp_next = 1'b0;
    if (below2) begin
      seg_next  = '0;
      frac_next = '0;
      flag_next = RANGE_BELOW;
    end else if (above2) begin
      seg_next  = ADDR_W'(cnt_m1);
      frac_next = '0;
      flag_next = RANGE_ABOVE;
    end else if (over) begin
      seg_next    = ADDR_W'(cnt_m2);
      frac_next   = FR_W'(1) << FRAC_BITS;
      flag_next   = RANGE_INSIDE;
      interp_next = 1'b1;
    end else begin
      seg_next    = ADDR_W'(ipart);
      frac_next   = {1'b0, frac_raw};
      flag_next   = RANGE_INSIDE;
      interp_next = 1'b1;
    end
    addr_a = seg_next;
    addr_b = interp_next ? seg_next + ADDR_W'(1) : seg_next;
    if (op2 == OP_WRITE) begin
      seg_out_next = widx2;
      flag_next    = RANGE_INSIDE;
      frac_next    = '0;
      interp_next  = 1'b0;
    end else begin
      seg_out_next = INDEX_W'(seg_next);
    end
  end

  assign wr_en = v2 && (op2 == OP_WRITE) && (32'(widx2) < 32'(TABLE_DEPTH));

  // stage 3: table read and write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(widx2)] <= wval2;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    op3     <= op2;
    flag3   <= flag_next;
    seg3    <= seg_out_next;
    frac3   <= frac_next;
    interp3 <= interp_next;
    wval3   <= wval2;
  end

  // stage 4: neighbor difference
  always_ff @(posedge clk) begin
    flag4   <= flag3;
    seg4    <= seg3;
    frac4   <= frac3;
    before4 <= (op3 == OP_WRITE) ? wval3 : rd_a;
    delta4  <= interp3 ? ({rd_b[DATA_W-1], rd_b} - {rd_a[DATA_W-1], rd_a}) : '0;
  end

  // stage 5: fraction multiply
  assign frac_s    = {1'b0, frac4};
  assign mult_next = MUL_W'(delta4) * MUL_W'(frac_s);

  always_ff @(posedge clk) begin
    flag5   <= flag4;
    seg5    <= seg4;
    before5 <= before4;
    mult5   <= mult_next;
  end

  // stage 6: floor shift and sum
  assign shifted = mult5 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    result.out_value  <= before5 + shifted[DATA_W-1:0];
    result.segment    <= seg5;
    result.range_flag <= flag5;
  end

  `PLTI_ASSERT_DELAY(a_result_follows, clk, rst, accept, LATENCY, done)
  `PLTI_ASSERT_IMPL(a_no_spurious_result, clk, rst, done, $past(accept, LATENCY))
  `PLTI_ASSERT_IMPL(a_above_segment, clk, rst, done && (result.range_flag == RANGE_ABOVE), result.segment == INDEX_W'(cnt_m1))

endmodule
